// ===== hw/rtl/jkoe_pkg.sv =====
// shared types and constants for the json keyed object extractor
// no dependencies; compiled first, imported by every module of the block

package jkoe_pkg;

    // default values handed to the top-level parameters
    localparam int MAX_KEY_BYTES_DEF = 16;
    localparam int DEPTH_BITS_DEF    = 16;

    // key register file geometry
    localparam int KEY_REG_BYTES = 16;
    localparam int KEY_LEN_W     = 5;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 64;

    // entries of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // characters of interest
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_LOW  = 2'd0,
        CFG_KEY_HIGH = 2'd1,
        CFG_KEY_LEN  = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_SEEK_KEY   = 2'd0,
        PH_SEEK_BRACE = 2'd1,
        PH_IN_BLOCK   = 2'd2,
        PH_FINISHED   = 2'd3
    } t_phase;

    // one classified byte on its way from front to back
    typedef struct packed {
        logic [7:0] text_byte;
        logic       is_end;
        logic       key_hit;
        logic       is_lbrace;
        logic       is_rbrace;
        logic       is_quote;
        logic       is_bslash;
    } t_token;

endpackage

// ===== hw/rtl/jkoe_in_if.sv =====
// valid/ready channel carrying one byte of json text per beat
// no dependencies

interface jkoe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       stream_end;

    modport source (output valid, output text_byte, output stream_end, input ready);
    modport sink   (input valid, input text_byte, input stream_end, output ready);
endinterface

// ===== hw/rtl/jkoe_out_if.sv =====
// valid/ready channel carrying one extracted byte or a status per beat
// no dependencies

interface jkoe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] block_byte;
    logic       block_done;
    logic       block_failed;

    modport source (output valid, output block_byte, output block_done,
                    output block_failed, input ready);
    modport sink   (input valid, input block_byte, input block_done,
                    input block_failed, output ready);
endinterface

// ===== hw/rtl/jkoe_front.sv =====
// front end: accepts text beats, runs the quoted-key window match, classifies bytes
// depends on jkoe_pkg and jkoe_in_if

module jkoe_front import jkoe_pkg::*; #(
    parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [CFG_DATA_W-1:0] i_key_low,
    input  logic [CFG_DATA_W-1:0] i_key_high,
    input  logic [KEY_LEN_W-1:0]  i_key_len,
    jkoe_in_if.sink               i_text,
    output logic                  o_push,
    output t_token                o_token,
    input  logic                  i_push_ready
);

    localparam int LEN_CAP = (MAX_KEY_BYTES < KEY_REG_BYTES) ? MAX_KEY_BYTES : KEY_REG_BYTES;
    localparam int WIN     = LEN_CAP + 2;
    localparam int CNT_W   = $clog2(WIN + 1);
    localparam int ELEN_W  = $clog2(LEN_CAP + 1);

    logic [7:0]        r_win [WIN];
    logic [7:0]        n_win [WIN];
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  n_cnt;
    logic              r_found;
    logic              n_found;
    logic [7:0]        key [LEN_CAP];
    logic [ELEN_W-1:0] eff_len;
    logic [LEN_CAP:0]  hit_by_len;
    logic              key_hit;
    logic              accept;

    assign i_text.ready = i_push_ready;
    assign accept       = i_text.valid && i_push_ready;

    // key bytes, first byte in the low bits of the low word
    always_comb begin
        for (int i = 0; i < LEN_CAP; i++) begin
            if (i < 8) begin
                key[i] = i_key_low[8*i +: 8];
            end else begin
                key[i] = i_key_high[8*(i-8) +: 8];
            end
        end
    end

    always_comb begin
        if (i_key_len > KEY_LEN_W'(LEN_CAP)) begin
            eff_len = ELEN_W'(LEN_CAP);
        end else begin
            eff_len = i_key_len[ELEN_W-1:0];
        end
    end

    // window after the current byte shifts in, newest at index 0
    always_comb begin
        n_win[0] = i_text.text_byte;
        for (int p = 1; p < WIN; p++) begin
            n_win[p] = r_win[p-1];
        end
        if (r_cnt == CNT_W'(WIN)) begin
            n_cnt = r_cnt;
        end else begin
            n_cnt = r_cnt + CNT_W'(1);
        end
    end

    // one needle compare per candidate length, then pick the configured one
    always_comb begin
        for (int l = 0; l <= LEN_CAP; l++) begin
            hit_by_len[l] = (n_cnt >= CNT_W'(l + 2)) && (n_win[0] == CH_QUOTE)
                            && (n_win[l+1] == CH_QUOTE);
            for (int i = 0; i < l; i++) begin
                hit_by_len[l] = hit_by_len[l] && (n_win[l-i] == key[i]);
            end
        end
    end

    assign key_hit = !r_found && hit_by_len[eff_len];
    assign n_found = r_found || key_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_found <= 1'b0;
        end else if (accept) begin
            if (i_text.stream_end) begin
                r_cnt   <= '0;
                r_found <= 1'b0;
            end else if (!r_found) begin
                r_cnt   <= n_cnt;
                r_found <= n_found;
            end
        end
    end

    // window contents past the fill count are never looked at
    always_ff @(posedge i_clk) begin
        if (accept && !r_found) begin
            r_win <= n_win;
        end
    end

    always_comb begin
        o_push            = accept;
        o_token.text_byte = i_text.text_byte;
        o_token.is_end    = i_text.stream_end;
        o_token.key_hit   = key_hit;
        o_token.is_lbrace = (i_text.text_byte == CH_LBRACE);
        o_token.is_rbrace = (i_text.text_byte == CH_RBRACE);
        o_token.is_quote  = (i_text.text_byte == CH_QUOTE);
        o_token.is_bslash = (i_text.text_byte == CH_BSLASH);
    end

endmodule

// ===== hw/rtl/jkoe_fifo.sv =====
// short token queue that decouples the front end from the back end
// depends on jkoe_pkg

module jkoe_fifo import jkoe_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_token i_token,
    output logic   o_push_ready,
    output logic   o_pop_valid,
    output t_token o_token,
    input  logic   i_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_token           r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_push_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_token      = r_mem[r_rd];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_token;
        end
    end

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("token queue holds more than its depth");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_push_ready)
        else $error("front pushed a token into a full queue");

endmodule

// ===== hw/rtl/jkoe_back.sv =====
// back end: phase machine, string/escape tracking, brace depth, result register
// depends on jkoe_pkg and jkoe_out_if

module jkoe_back import jkoe_pkg::*; #(
    parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_tok_valid,
    input  t_token      i_token,
    output logic        o_tok_pop,
    jkoe_out_if.source  o_block
);

    t_phase                r_phase;
    t_phase                n_phase;
    logic                  r_in_str;
    logic                  n_in_str;
    logic                  r_bslash;
    logic                  n_bslash;
    logic [DEPTH_BITS-1:0] r_depth;
    logic [DEPTH_BITS-1:0] n_depth;
    logic                  r_out_valid;
    logic [7:0]            r_out_byte;
    logic                  r_out_done;
    logic                  r_out_fail;
    logic                  res_has;
    logic [7:0]            res_byte;
    logic                  res_done;
    logic                  res_fail;

    assign o_tok_pop = i_tok_valid && (!r_out_valid || o_block.ready);

    always_comb begin
        n_phase  = r_phase;
        n_in_str = r_in_str;
        n_bslash = r_bslash;
        n_depth  = r_depth;
        res_has  = 1'b0;
        res_byte = i_token.text_byte;
        res_done = 1'b0;
        res_fail = 1'b0;
        case (r_phase)
            PH_SEEK_KEY: begin
                if (i_token.key_hit) begin
                    n_phase = PH_SEEK_BRACE;
                end
            end
            PH_SEEK_BRACE: begin
                if (i_token.is_lbrace) begin
                    n_phase  = PH_IN_BLOCK;
                    n_depth  = DEPTH_BITS'(1);
                    n_in_str = 1'b0;
                    n_bslash = 1'b0;
                    res_has  = 1'b1;
                end
            end
            PH_IN_BLOCK: begin
                res_has = 1'b1;
                if (r_in_str) begin
                    if (r_bslash) begin
                        n_bslash = 1'b0;
                    end else if (i_token.is_bslash) begin
                        n_bslash = 1'b1;
                    end else if (i_token.is_quote) begin
                        n_in_str = 1'b0;
                    end
                end else if (i_token.is_quote) begin
                    n_in_str = 1'b1;
                end else if (i_token.is_lbrace) begin
                    if (r_depth == '1) begin
                        res_byte = '0;
                        res_fail = 1'b1;
                        n_phase  = PH_FINISHED;
                    end else begin
                        n_depth = r_depth + DEPTH_BITS'(1);
                    end
                end else if (i_token.is_rbrace) begin
                    if (r_depth != '0) begin
                        n_depth = r_depth - DEPTH_BITS'(1);
                    end
                    if (r_depth <= DEPTH_BITS'(1)) begin
                        res_done = 1'b1;
                        n_phase  = PH_FINISHED;
                    end
                end
            end
            PH_FINISHED: begin
                res_has = 1'b0;
            end
            default: begin
                n_phase = PH_SEEK_KEY;
            end
        endcase
        // end of text: report failure unless the block closed, then start over
        if (i_token.is_end) begin
            if (n_phase != PH_FINISHED) begin
                res_has  = 1'b1;
                res_byte = '0;
                res_done = 1'b0;
                res_fail = 1'b1;
            end
            n_phase  = PH_SEEK_KEY;
            n_in_str = 1'b0;
            n_bslash = 1'b0;
            n_depth  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SEEK_KEY;
            r_in_str    <= 1'b0;
            r_bslash    <= 1'b0;
            r_depth     <= '0;
            r_out_valid <= 1'b0;
        end else if (o_tok_pop) begin
            r_phase     <= n_phase;
            r_in_str    <= n_in_str;
            r_bslash    <= n_bslash;
            r_depth     <= n_depth;
            r_out_valid <= res_has;
        end else if (o_block.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_tok_pop && res_has) begin
            r_out_byte <= res_byte;
            r_out_done <= res_done;
            r_out_fail <= res_fail;
        end
    end

    assign o_block.valid        = r_out_valid;
    assign o_block.block_byte   = r_out_byte;
    assign o_block.block_done   = r_out_done;
    assign o_block.block_failed = r_out_fail;

    a_done_xor_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_done && r_out_fail))
        else $error("result marked both done and failed");

    a_fail_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_fail) |-> (r_out_byte == '0))
        else $error("failure result carries a nonzero byte");

    a_depth_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IN_BLOCK) |-> (r_depth != '0))
        else $error("inside a block with zero brace depth");

    a_end_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tok_pop && i_token.is_end) |=> (r_phase == PH_SEEK_KEY && r_depth == '0))
        else $error("state not cleared after end of text");

endmodule

// ===== hw/rtl/json_keyed_object_extractor_unit.sv =====
// top level of the json keyed object extractor: config registers, front, queue, back
// depends on jkoe_pkg, jkoe_in_if, jkoe_out_if, jkoe_front, jkoe_fifo, jkoe_back

// The unit scans a json text stream, one byte per beat, for the first literal
// occurrence of the configured key wrapped in double quotes (anywhere, string
// or not), then waits for the next '{' and forwards that brace and every
// following byte until the matching '}' closes the object; that last beat
// carries block_done. Braces inside strings and escaped characters inside
// strings do not count toward depth. If the text ends first, or a '{' arrives
// at the maximum depth (2**DEPTH_BITS - 1), a single beat with block_failed
// set and a zero byte is sent instead; after the byte flagged stream_end all
// scan state returns to reset and the next text starts clean. Throughput is
// one byte per clock while the sink keeps up: the front compares the whole
// needle window against every candidate key length in parallel each cycle,
// and the back updates phase, string flags and depth for each popped byte.
// A result beat passes through the token queue and the registered output
// stage before it is valid on the output. The front and back are joined by
// a two-entry token queue and the output is registered, so when the sink
// stalls, input ready only drops once that queue is full. Keys longer than
// min(MAX_KEY_BYTES, 16) are cut to that length. Config registers
// are written through a plain write port (index 0 key bytes 0-7, index 1 key
// bytes 8-15, index 2 key length) and should only be changed between texts.

module json_keyed_object_extractor_unit import jkoe_pkg::*; #(
    parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF,
    parameter int DEPTH_BITS    = DEPTH_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    jkoe_in_if.sink               i_text,
    jkoe_out_if.source            o_block,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // key registers
    logic [CFG_DATA_W-1:0] r_key_low;
    logic [CFG_DATA_W-1:0] r_key_high;
    logic [KEY_LEN_W-1:0]  r_key_len;

    // front to queue
    logic   front_push;
    t_token front_token;
    logic   queue_ready;

    // queue to back
    logic   queue_valid;
    t_token queue_token;
    logic   back_pop;

    // config writes; unused index is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
            r_key_len  <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                CFG_KEY_LEN:  r_key_len  <= i_cfg_data[KEY_LEN_W-1:0];
                default: begin
                    r_key_len <= r_key_len;
                end
            endcase
        end
    end

    // needle match and byte classification
    jkoe_front #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_key_low    (r_key_low),
        .i_key_high   (r_key_high),
        .i_key_len    (r_key_len),
        .i_text       (i_text),
        .o_push       (front_push),
        .o_token      (front_token),
        .i_push_ready (queue_ready)
    );

    // decoupling queue, lets the front keep taking beats while the sink stalls
    jkoe_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (front_push),
        .i_token      (front_token),
        .o_push_ready (queue_ready),
        .o_pop_valid  (queue_valid),
        .o_token      (queue_token),
        .i_pop        (back_pop)
    );

    // object tracking and the registered result beat
    jkoe_back #(
        .DEPTH_BITS (DEPTH_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (queue_valid),
        .i_token     (queue_token),
        .o_tok_pop   (back_pop),
        .o_block     (o_block)
    );

endmodule

// ===== dv/tb_json_keyed_object_extractor_unit.sv =====
// testbench for json_keyed_object_extractor_unit: directed texts and random json texts
// depends on jkoe_pkg, jkoe_in_if, jkoe_out_if and the rtl of the unit

import jkoe_pkg::*;

typedef struct packed {
    logic [7:0] block_byte;
    logic       block_done;
    logic       block_failed;
} t_block_beat;

// mirrors the extractor byte by byte and holds the beats it must produce
class object_block_tracker;
    localparam int          WINDOW_BYTES = MAX_KEY_BYTES_DEF + 2;
    localparam int unsigned DEPTH_LIMIT  = (32'd1 << DEPTH_BITS_DEF) - 1;

    logic [CFG_DATA_W-1:0] key_low;
    logic [CFG_DATA_W-1:0] key_high;
    logic [KEY_LEN_W-1:0]  key_len;

    logic [7:0]  window [WINDOW_BYTES];
    int unsigned window_fill;
    t_phase      scan_phase;
    bit          in_string;
    bit          escaped;
    int unsigned depth;

    t_block_beat pending_beats [$];
    int unsigned beats_checked;
    int unsigned mismatches;
    int unsigned dones_expected;
    int unsigned fails_expected;

    function new();
        key_low  = '0;
        key_high = '0;
        key_len  = '0;
        beats_checked  = 0;
        mismatches     = 0;
        dones_expected = 0;
        fails_expected = 0;
        clear_scan();
    endfunction

    function void clear_scan();
        foreach (window[i]) window[i] = 8'h00;
        window_fill = 0;
        scan_phase  = PH_SEEK_KEY;
        in_string   = 1'b0;
        escaped     = 1'b0;
        depth       = 0;
    endfunction

    function void write_register(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_KEY_LOW:  key_low  = data;
            CFG_KEY_HIGH: key_high = data;
            CFG_KEY_LEN:  key_len  = data[KEY_LEN_W-1:0];
            default: ;
        endcase
    endfunction

    function void take_text_byte(logic [7:0] b, logic last);
        bit           emit;
        bit           hit;
        t_block_beat  beat;
        int unsigned  len;
        int           i;
        logic [127:0] key_all;
        emit = 1'b0;
        beat = '0;
        case (scan_phase)
            PH_SEEK_KEY: begin
                for (i = WINDOW_BYTES - 1; i > 0; i--) window[i] = window[i-1];
                window[0] = b;
                if (window_fill < WINDOW_BYTES) window_fill++;
                // needle is quote, key (newest byte last), quote
                len = key_len;
                if (len > MAX_KEY_BYTES_DEF) len = MAX_KEY_BYTES_DEF;
                if (len > KEY_REG_BYTES) len = KEY_REG_BYTES;
                key_all = {key_high, key_low};
                hit = (window_fill >= len + 2) && (window[0] == CH_QUOTE)
                      && (window[len+1] == CH_QUOTE);
                for (i = 0; i < len; i++) begin
                    if (window[len-i] != key_all[8*i +: 8]) hit = 1'b0;
                end
                if (hit) scan_phase = PH_SEEK_BRACE;
            end
            PH_SEEK_BRACE: begin
                if (b == CH_LBRACE) begin
                    scan_phase = PH_IN_BLOCK;
                    depth      = 1;
                    in_string  = 1'b0;
                    escaped    = 1'b0;
                    emit       = 1'b1;
                    beat.block_byte = b;
                end
            end
            PH_IN_BLOCK: begin
                emit = 1'b1;
                beat.block_byte = b;
                if (in_string) begin
                    if (escaped) escaped = 1'b0;
                    else if (b == CH_BSLASH) escaped = 1'b1;
                    else if (b == CH_QUOTE) in_string = 1'b0;
                end else if (b == CH_QUOTE) begin
                    in_string = 1'b1;
                end else if (b == CH_LBRACE) begin
                    if (depth >= DEPTH_LIMIT) begin
                        beat.block_byte   = 8'h00;
                        beat.block_failed = 1'b1;
                        scan_phase        = PH_FINISHED;
                    end else begin
                        depth++;
                    end
                end else if (b == CH_RBRACE) begin
                    if (depth > 0) depth--;
                    if (depth == 0) begin
                        beat.block_done = 1'b1;
                        scan_phase      = PH_FINISHED;
                    end
                end
            end
            default: ;
        endcase
        if (last) begin
            if (scan_phase != PH_FINISHED) begin
                emit = 1'b1;
                beat = '0;
                beat.block_failed = 1'b1;
            end
            clear_scan();
        end
        if (emit) begin
            pending_beats = {pending_beats, beat};
            if (beat.block_done) dones_expected++;
            if (beat.block_failed) fails_expected++;
        end
    endfunction

    function void check_block_beat(t_block_beat got);
        t_block_beat want;
        if (pending_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: unexpected beat byte=%h done=%b failed=%b",
                         got.block_byte, got.block_done, got.block_failed);
            return;
        end
        want = pending_beats.pop_front();
        beats_checked++;
        if (got.block_byte !== want.block_byte || got.block_done !== want.block_done ||
            got.block_failed !== want.block_failed) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch at beat %0d: byte exp %h got %h, done exp %b got %b,%s",
                         beats_checked, want.block_byte, got.block_byte, want.block_done,
                         got.block_done, $sformatf(" failed exp %b got %b",
                         want.block_failed, got.block_failed));
        end
    endfunction
endclass

module tb_json_keyed_object_extractor_unit;

    // cycles to let pass once the last expected beat has arrived
    localparam int DRAIN_CYCLES   = 8;
    // text bytes per idling phase of the random part
    localparam int BYTES_PER_MODE = 290;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    jkoe_in_if  text_if ();
    jkoe_out_if block_if ();

    json_keyed_object_extractor_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_text     (text_if),
        .o_block    (block_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    object_block_tracker tracker = new();

    // idling knobs, percent of cycles
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    // long receiver hold-off, handed to the receiver process
    int unsigned hold_request  = 0;

    int unsigned text_bytes_sent = 0;
    int unsigned texts_sent      = 0;

    logic [7:0] text_buf [$];

    // free-running clock, period 10
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // safety net against a hung handshake
    initial begin
        #15_000_000;
        $display("tb: failure");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off when asked for one
    initial begin : receiver
        int unsigned hold_left;
        hold_left = 0;
        block_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                block_if.ready = 1'b0;
                hold_left--;
            end else begin
                block_if.ready = ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // every accepted output beat goes against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && block_if.valid && block_if.ready)
            tracker.check_block_beat(t_block_beat'{block_if.block_byte,
                                                   block_if.block_done,
                                                   block_if.block_failed});
    end

    // one text beat: random idle cycles first, then hold valid until taken
    task automatic send_byte(input logic [7:0] b, input logic last);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            text_if.valid = 1'b0;
            @(negedge i_clk);
        end
        text_if.valid      = 1'b1;
        text_if.text_byte  = b;
        text_if.stream_end = last;
        do @(posedge i_clk); while (!text_if.ready);
        tracker.take_text_byte(b, last);
        text_bytes_sent++;
    endtask

    // whole buffer as one text, stream end on its last byte
    task automatic send_text();
        for (int i = 0; i < text_buf.size(); i++)
            send_byte(text_buf[i], i == text_buf.size() - 1);
        texts_sent++;
    endtask

    // register writes only happen with the unit idle
    task automatic write_register(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        @(posedge i_clk);
        tracker.write_register(idx, data);
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_key(input logic [63:0] lo, input logic [63:0] hi,
                           input logic [KEY_LEN_W-1:0] len);
        logic [CFG_DATA_W-1:0] len_word;
        // junk above the length field must be dropped
        len_word = {$urandom, $urandom};
        len_word[KEY_LEN_W-1:0] = len;
        write_register(CFG_KEY_LOW, lo);
        write_register(CFG_KEY_HIGH, hi);
        write_register(CFG_KEY_LEN, len_word);
    endtask

    // wait for all expected beats, then a drain period for bytes with no result
    task automatic wait_drained();
        @(negedge i_clk);
        text_if.valid = 1'b0;
        while (tracker.pending_beats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // random byte that is none of the structural characters
    function automatic logic [7:0] filler_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == CH_LBRACE || b == CH_RBRACE || b == CH_QUOTE || b == CH_BSLASH);
        return b;
    endfunction

    // append one byte to the text under construction
    task automatic add_byte(input logic [7:0] b);
        text_buf = {text_buf, b};
    endtask

    task automatic push_noise(input int n);
        repeat (n) add_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic push_needle();
        logic [127:0] key_all;
        int           len;
        key_all = {tracker.key_high, tracker.key_low};
        len = (tracker.key_len > KEY_REG_BYTES) ? KEY_REG_BYTES : tracker.key_len;
        add_byte(CH_QUOTE);
        for (int i = 0; i < len; i++) add_byte(key_all[8*i +: 8]);
        add_byte(CH_QUOTE);
    endtask

    // object with strings, escapes and nesting down to the given budget
    task automatic push_object(input int budget);
        int n;
        int m;
        add_byte(CH_LBRACE);
        n = $urandom_range(0, 4);
        repeat (n) begin
            case ($urandom_range(0, 6))
                0, 1, 2: add_byte(filler_byte());
                3, 4: begin
                    // string: braces and escaped bytes must not count
                    add_byte(CH_QUOTE);
                    m = $urandom_range(0, 4);
                    repeat (m) begin
                        case ($urandom_range(0, 3))
                            0: add_byte(filler_byte());
                            1: add_byte(CH_LBRACE);
                            2: add_byte(CH_RBRACE);
                            default: begin
                                add_byte(CH_BSLASH);
                                add_byte(8'($urandom_range(0, 255)));
                            end
                        endcase
                    end
                    add_byte(CH_QUOTE);
                end
                default: begin
                    if (budget > 0) push_object(budget - 1);
                    else add_byte(filler_byte());
                end
            endcase
        end
        add_byte(CH_RBRACE);
    endtask

    // mostly keyed objects; some cut short, some with no brace, some pure noise
    task automatic build_text();
        int kind;
        int cut;
        text_buf.delete();
        kind = $urandom_range(0, 99);
        push_noise($urandom_range(0, 6));
        if (kind < 85) push_needle();
        if (kind < 75) begin
            repeat ($urandom_range(0, 3)) add_byte(filler_byte());
            push_object(3);
            push_noise($urandom_range(0, 4));
            if (kind >= 63) begin
                cut = $urandom_range(1, text_buf.size() - 1);
                while (text_buf.size() > cut) void'(text_buf.pop_back());
            end
        end else if (kind < 85) begin
            repeat ($urandom_range(1, 6)) add_byte(filler_byte());
        end else begin
            push_noise($urandom_range(1, 12));
        end
    endtask

    initial begin : stimulus
        int unsigned target;
        i_rst_n            = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = CFG_KEY_LOW;
        cfg_data           = '0;
        text_if.valid      = 1'b0;
        text_if.text_byte  = 8'h00;
        text_if.stream_end = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // ---- directed part, empty key: the needle is two quotes
        set_key('0, '0, 0);
        // block closes on the very byte that ends the text
        text_buf = '{CH_QUOTE, CH_QUOTE, CH_LBRACE, CH_RBRACE};
        send_text();
        // brace inside a string after an escape, then a trailing byte after done
        text_buf = '{CH_QUOTE, CH_QUOTE, CH_LBRACE, CH_QUOTE, CH_BSLASH, CH_RBRACE,
                     CH_QUOTE, CH_RBRACE, 8'h78};
        send_text();
        // text with no needle at all, byte extremes
        text_buf = '{8'h00, 8'hFF};
        send_text();
        // text ends inside the block
        text_buf = '{CH_QUOTE, CH_QUOTE, CH_LBRACE, 8'h61};
        send_text();
        wait_drained();
        // key that is itself an open brace: search starts after the closing quote
        set_key(64'(CH_LBRACE), '0, 1);
        text_buf = '{CH_QUOTE, CH_LBRACE, CH_QUOTE, CH_LBRACE, CH_RBRACE};
        send_text();
        wait_drained();

        // ---- random part, one idling pattern per phase
        target = text_bytes_sent;
        for (int mode = 0; mode < 4; mode++) begin
            case (mode)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                    set_key({$urandom, $urandom}, {$urandom, $urandom}, 16);
                end
                1: begin
                    send_idle_pct = 65;
                    stall_pct     = 0;
                    // length beyond the register file gets cut to sixteen
                    set_key('1, '0, 31);
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 65;
                    set_key({$urandom, $urandom}, {$urandom, $urandom},
                            KEY_LEN_W'($urandom_range(1, 15)));
                end
                default: begin
                    send_idle_pct = 8;
                    stall_pct     = 8;
                    set_key({$urandom, $urandom}, {$urandom, $urandom},
                            KEY_LEN_W'($urandom_range(0, 31)));
                end
            endcase
            // long receiver hold-off while the sender keeps pushing; fills the queue
            if (mode == 0) hold_request = 300;
            target += BYTES_PER_MODE;
            while (text_bytes_sent < target) begin
                build_text();
                send_text();
            end
            wait_drained();
        end

        repeat (20) @(posedge i_clk);
        if (tracker.pending_beats.size() != 0) begin
            tracker.mismatches += tracker.pending_beats.size();
            $display("mismatch: %0d expected beats never arrived", tracker.pending_beats.size());
        end
        $display("covered %0d texts, %0d text bytes, %0d output beats checked",
                 texts_sent, text_bytes_sent, tracker.beats_checked);
        $display("of those beats %0d closed a block and %0d reported a failure, %0d mismatches",
                 tracker.dones_expected, tracker.fails_expected, tracker.mismatches);
        if (tracker.mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
